>>> rtl/nbc_pkg.sv
// ----------------------------------------------------------------------------
// nbc_pkg
// Types, character constants and helpers for the nested bracket copier.
// ----------------------------------------------------------------------------
package nbc_pkg;

  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_RPAREN    = 8'h29;
  localparam logic [CHAR_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;

  typedef logic [1:0] closer_code_t;
  localparam closer_code_t CODE_BRACE   = 2'd0;
  localparam closer_code_t CODE_PAREN   = 2'd1;
  localparam closer_code_t CODE_BRACKET = 2'd2;
  localparam closer_code_t CODE_UNUSED  = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FLUSH
  } nbc_state_t;

  typedef struct packed {
    logic load_char;
    logic flush_step;
    logic clear;
  } nbc_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic depth_one;
    logic out_free;
  } nbc_sts_t;

  function automatic logic [CHAR_W-1:0] closer_char(input closer_code_t code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      CODE_BRACE:   c = CH_RBRACE;
      CODE_PAREN:   c = CH_RPAREN;
      CODE_BRACKET: c = CH_RBRACKET;
      CODE_UNUSED:  c = CH_RBRACKET;
      default:      c = CH_RBRACKET;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

>>> rtl/nbc_ctrl.sv
// ----------------------------------------------------------------------------
// nbc_ctrl
// Sequencer: accepts words, runs end-of-input flush one level per free cycle.
// ----------------------------------------------------------------------------
module nbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_end_of_input,
  output logic              in_ready,
  input  nbc_pkg::nbc_sts_t sts,
  output nbc_pkg::nbc_cmd_t cmd
);

  nbc_pkg::nbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.load_char  = 1'b0;
    cmd.flush_step = 1'b0;
    cmd.clear      = 1'b0;
    unique case (state_r)
      nbc_pkg::ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (!in_end_of_input) begin
            cmd.load_char = 1'b1;
          end else if (sts.depth_zero) begin
            cmd.clear = 1'b1;
          end else begin
            state_nxt = nbc_pkg::ST_FLUSH;
          end
        end
      end
      nbc_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush_step = 1'b1;
          if (sts.depth_one) begin
            cmd.clear = 1'b1;
            state_nxt = nbc_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = nbc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/nbc_dp.sv
// ----------------------------------------------------------------------------
// nbc_dp
// Datapath: closer stack, lexical state, config register, output register.
// ----------------------------------------------------------------------------
module nbc_dp #(
  parameter int MAX_NEST = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic [nbc_pkg::CHAR_W-1:0]   in_ch,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [nbc_pkg::CHAR_W-1:0]   out_char,
  output logic                         out_last_of_run,
  output logic                         out_nest_overflow,
  input  nbc_pkg::nbc_cmd_t            cmd,
  output nbc_pkg::nbc_sts_t            sts
);

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  nbc_pkg::closer_code_t mem [0:(1<<AW)-1];
  nbc_pkg::closer_code_t top_r;

  logic [DW-1:0] depth_r, depth_nxt;
  logic          in_string_r, in_string_nxt;
  logic          squote_r, squote_nxt;
  logic          esc_r, esc_nxt;
  logic          pnl_r, pnl_nxt;
  logic          top_sup_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [nbc_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic                       push;
  nbc_pkg::closer_code_t      push_code;
  logic [DW-1:0]              dm1;
  logic [AW-1:0]              rd_addr;
  logic                       depth_zero;
  logic [nbc_pkg::CHAR_W-1:0] quote_ch;
  logic                       suppress;
  logic                       is_open;

  assign depth_zero     = (depth_r == '0);
  assign sts.depth_zero = depth_zero;
  assign sts.depth_one  = (depth_r == DW'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign quote_ch = squote_r ? nbc_pkg::CH_SQUOTE : nbc_pkg::CH_DQUOTE;
  assign suppress = depth_zero ? top_sup_r : (top_r != nbc_pkg::CODE_BRACE);
  assign is_open  = (in_ch == nbc_pkg::CH_LBRACE) || (in_ch == nbc_pkg::CH_LPAREN) ||
                    (in_ch == nbc_pkg::CH_LBRACKET);

  always_comb begin
    depth_nxt     = depth_r;
    in_string_nxt = in_string_r;
    squote_nxt    = squote_r;
    esc_nxt       = esc_r;
    pnl_nxt       = pnl_r;
    push          = 1'b0;
    push_code     = nbc_pkg::CODE_BRACE;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (cmd.load_char) begin
      out_char_nxt = in_ch;
      out_last_nxt = 1'b1;
      out_ovf_nxt  = 1'b0;
      priority if (in_string_r) begin
        out_valid_nxt = 1'b1;
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_ch == quote_ch) begin
          in_string_nxt = 1'b0;
          pnl_nxt       = 1'b0;
        end else if (in_ch == nbc_pkg::CH_BACKSLASH) begin
          esc_nxt = 1'b1;
        end
      end else if (!depth_zero && in_ch == nbc_pkg::closer_char(top_r)) begin
        out_valid_nxt = 1'b1;
        depth_nxt     = depth_r - DW'(1);
        pnl_nxt       = 1'b0;
      end else if (suppress && pnl_r && nbc_pkg::is_ws(in_ch)) begin
        pnl_nxt = (in_ch == nbc_pkg::CH_NEWLINE);
      end else begin
        out_valid_nxt = 1'b1;
        pnl_nxt       = (in_ch == nbc_pkg::CH_NEWLINE);
        if (in_ch == nbc_pkg::CH_DQUOTE || in_ch == nbc_pkg::CH_SQUOTE) begin
          in_string_nxt = 1'b1;
          squote_nxt    = (in_ch == nbc_pkg::CH_SQUOTE);
          esc_nxt       = 1'b0;
          pnl_nxt       = 1'b0;
        end else if (is_open) begin
          if (depth_r == DW'(MAX_NEST)) begin
            out_ovf_nxt = 1'b1;
          end else begin
            push      = 1'b1;
            push_code = (in_ch == nbc_pkg::CH_LBRACE) ? nbc_pkg::CODE_BRACE :
                        (in_ch == nbc_pkg::CH_LPAREN) ? nbc_pkg::CODE_PAREN :
                                                        nbc_pkg::CODE_BRACKET;
            depth_nxt = depth_r + DW'(1);
            pnl_nxt   = 1'b0;
          end
        end
      end
    end

    if (cmd.flush_step) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = nbc_pkg::closer_char(top_r);
      out_last_nxt  = (depth_r == DW'(1));
      out_ovf_nxt   = 1'b0;
      depth_nxt     = depth_r - DW'(1);
    end

    if (cmd.clear) begin
      depth_nxt     = '0;
      in_string_nxt = 1'b0;
      squote_nxt    = 1'b0;
      esc_nxt       = 1'b0;
      pnl_nxt       = 1'b0;
    end
  end

  assign dm1     = depth_nxt - DW'(1);
  assign rd_addr = dm1[AW-1:0];

  // top_r mirrors the entry below depth; bypass on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[depth_r[AW-1:0]] <= push_code;
      top_r                <= push_code;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      in_string_r <= 1'b0;
      squote_r    <= 1'b0;
      esc_r       <= 1'b0;
      pnl_r       <= 1'b0;
      top_sup_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      in_string_r <= in_string_nxt;
      squote_r    <= squote_nxt;
      esc_r       <= esc_nxt;
      pnl_r       <= pnl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        top_sup_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_last_of_run   = out_last_r;
  assign out_nest_overflow = out_ovf_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_NEST))
    else $error("nesting depth beyond stack size");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_step |-> !depth_zero)
    else $error("flush step with empty stack");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (depth_r == '0) && !in_string_r && !esc_r && !pnl_r)
    else $error("state not cleared at end of stream");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_char && out_ovf_nxt) |-> (depth_r == DW'(MAX_NEST)))
    else $error("overflow flagged with room on stack");

endmodule

>>> rtl/nested_bracket_copier_unit.sv
// ----------------------------------------------------------------------------
// nested_bracket_copier_unit
// Copies a character stream, tracks bracket nesting and strings, flushes
// the closers of open levels at end of stream.
// ----------------------------------------------------------------------------
// A character word is written to the output register when it is accepted.
// Throughput: one character per cycle while the output side takes words.
// End of stream: after the accept, one closer per open level is emitted,
//   innermost closer first; no new input is taken until the flush is done.
// Reset: synchronous, active low; clears nesting and string state and sets
//   top_suppress to 0. The closer stack memory is not cleared.
module nested_bracket_copier_unit #(
  parameter int MAX_NEST = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nbc_pkg::CHAR_W-1:0] in_ch,
  input  logic                       in_end_of_input,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [nbc_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last_of_run,
  output logic                       out_nest_overflow
);

  nbc_pkg::nbc_cmd_t cmd;
  nbc_pkg::nbc_sts_t sts;

  nbc_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_end_of_input (in_end_of_input),
    .in_ready        (in_ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  nbc_dp #(
    .MAX_NEST (MAX_NEST)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_ch             (in_ch),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_char          (out_char),
    .out_last_of_run   (out_last_of_run),
    .out_nest_overflow (out_nest_overflow),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
